FILE: hw/rtl/wpp_pkg.sv
package wpp_pkg;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_SIZE = 3'd1,
    PH_WAVE = 3'd2,
    PH_HDR  = 3'd3,
    PH_FMT  = 3'd4,
    PH_DATA = 3'd5,
    PH_SKIP = 3'd6,
    PH_PAD  = 3'd7
  } wpp_phase_t;

  typedef enum logic [3:0] {
    ST_RUNNING      = 4'd0,
    ST_DONE_OK      = 4'd1,
    ST_NOT_RIFF     = 4'd2,
    ST_NOT_WAVE     = 4'd3,
    ST_NOT_PCM      = 4'd4,
    ST_BAD_CHANNELS = 4'd5,
    ST_BAD_RATE     = 4'd6,
    ST_BAD_BITS     = 4'd7,
    ST_DATA_NO_FMT  = 4'd8,
    ST_SECOND_DATA  = 4'd9,
    ST_NO_DATA      = 4'd10,
    ST_FMT_SHORT    = 4'd11
  } wpp_status_t;

  localparam logic [31:0] TAG_RIFF       = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE       = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT        = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA       = 32'h6174_6164;
  localparam logic [15:0] AUDIO_FMT_PCM  = 16'd1;
  localparam logic [15:0] PCM_BITS       = 16'd16;
  localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
  localparam logic [31:0] RATE_RESET     = 32'd44100;

  // One request from the parser to the frame builder.
  typedef struct packed {
    logic        is_data;   // data chunk byte
    logic [7:0]  data_byte;
    logic        stereo;
    logic        restart;   // drop any partial frame after this request
    logic        emit;      // request carries a final or error status
    wpp_status_t status;
  } wpp_op_t;

endpackage

FILE: hw/rtl/wav_pcm16_stream_parser.sv
// WAV PCM16 stream parser.
// Input queue port: one file byte per request on in_data_byte, with
// in_last_byte marking the final byte of a file. A byte is taken when
// in_push is high and in_full is low. The parser checks the RIFF/WAVE
// header, walks and skips chunks, validates fmt against the rate held in
// the cfg_data register (written on cfg_valid, cfg_ready is always high),
// and turns data bytes into stereo Q1.15 frames (mono is duplicated).
// Result queue port: a result waits on the out_ ports while out_empty is
// low and leaves on out_pop. A result appears for each finished frame,
// for each detected error, and for the last byte of a file that had no
// error before it. Throughput is one byte per clock while in_full is low.
// A result passes through a small request queue, which the parser writes,
// and a one-entry output register, which the frame builder fills from it.
// When out_pop stays low the builder stops only on requests that yield a
// result; the queue then fills and in_full rises.
// Reset (rst_n low, synchronous) empties both queues, restarts parsing
// at the RIFF tag and sets the required rate to 44100 Hz.
module wav_pcm16_stream_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_has_frame,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic [3:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import wpp_pkg::*;

  wpp_op_t op, q_op;
  logic    op_valid;
  logic    q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  wpp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .op_valid     (op_valid),
    .op           (op)
  );

  wpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (op_valid),
    .wr_op (op),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_op (q_op),
    .empty (q_empty)
  );

  wpp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_op             (q_op),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_has_frame    (out_has_frame),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_status       (out_status)
  );

endmodule

FILE: hw/rtl/wpp_front.sv
module wpp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  logic            q_full,
  input  logic            cfg_valid,
  input  logic [31:0]     cfg_data,
  output logic            op_valid,
  output wpp_pkg::wpp_op_t op
);
  import wpp_pkg::*;

  wpp_phase_t  phase_r, phase_nxt;
  logic [4:0]  fcnt_r, fcnt_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        data_seen_r, data_seen_nxt;
  logic        stereo_r, stereo_nxt;
  logic        err_r, err_nxt;
  logic        pad_r, pad_nxt;
  logic [31:0] rate_r;

  logic        accept;
  logic [31:0] ws;
  logic [4:0]  fcnt_inc;
  logic [31:0] remain_dec;
  logic [15:0] hi;
  wpp_status_t err_code;
  logic        has_err;
  logic        chunk_end;
  wpp_status_t last_status;

  assign accept     = in_push && !q_full;
  assign ws         = {in_data_byte, shift_r[31:8]};
  assign hi         = ws[31:16];
  assign fcnt_inc   = fcnt_r + 5'd1;
  assign remain_dec = remain_r - 32'd1;

  always_comb begin
    phase_nxt     = phase_r;
    fcnt_nxt      = fcnt_r;
    shift_nxt     = shift_r;
    tag_nxt       = tag_r;
    remain_nxt    = remain_r;
    fmt_seen_nxt  = fmt_seen_r;
    data_seen_nxt = data_seen_r;
    stereo_nxt    = stereo_r;
    err_nxt       = err_r;
    pad_nxt       = pad_r;
    err_code      = ST_RUNNING;
    chunk_end     = 1'b0;
    last_status   = ST_RUNNING;

    if (!err_r) begin
      unique case (phase_r)
        PH_RIFF, PH_SIZE, PH_WAVE: begin
          shift_nxt = ws;
          fcnt_nxt  = fcnt_inc;
          if (fcnt_inc >= 5'd4) begin
            fcnt_nxt = '0;
            if (phase_r == PH_RIFF) begin
              if (ws != TAG_RIFF) err_code = ST_NOT_RIFF;
              else phase_nxt = PH_SIZE;
            end else if (phase_r == PH_SIZE) begin
              phase_nxt = PH_WAVE;
            end else begin
              if (ws != TAG_WAVE) err_code = ST_NOT_WAVE;
              else phase_nxt = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          shift_nxt = ws;
          fcnt_nxt  = fcnt_inc;
          if (fcnt_inc == 5'd4) tag_nxt = ws;
          if (fcnt_inc >= 5'd8) begin
            // open the chunk named by the stored tag
            remain_nxt = ws;
            pad_nxt    = ws[0];
            fcnt_nxt   = '0;
            if (tag_r == TAG_FMT) begin
              if (ws < FMT_MIN_SIZE) err_code = ST_FMT_SHORT;
              else phase_nxt = PH_FMT;
            end else if (tag_r == TAG_DATA) begin
              if (data_seen_r) err_code = ST_SECOND_DATA;
              else if (!fmt_seen_r) err_code = ST_DATA_NO_FMT;
              else begin
                data_seen_nxt = 1'b1;
                phase_nxt     = PH_DATA;
              end
            end else begin
              phase_nxt = PH_SKIP;
            end
            if (err_code == ST_RUNNING && ws == '0) begin
              phase_nxt = ws[0] ? PH_PAD : PH_HDR;
              pad_nxt   = 1'b0;
            end
          end
        end
        PH_FMT: begin
          shift_nxt = ws;
          if (fcnt_r < 5'd16) fcnt_nxt = fcnt_inc;
          if (fcnt_r == 5'd1 && hi != AUDIO_FMT_PCM) begin
            err_code = ST_NOT_PCM;
          end else if (fcnt_r == 5'd3) begin
            if (hi != 16'd1 && hi != 16'd2) err_code = ST_BAD_CHANNELS;
            else stereo_nxt = (hi == 16'd2);
          end else if (fcnt_r == 5'd7 && ws != rate_r) begin
            err_code = ST_BAD_RATE;
          end else if (fcnt_r == 5'd15) begin
            if (hi != PCM_BITS) err_code = ST_BAD_BITS;
            else fmt_seen_nxt = 1'b1;
          end
          if (err_code == ST_RUNNING) begin
            remain_nxt = remain_dec;
            chunk_end  = (remain_dec == '0);
          end
        end
        PH_DATA, PH_SKIP: begin
          remain_nxt = remain_dec;
          chunk_end  = (remain_dec == '0);
        end
        PH_PAD: begin
          phase_nxt = PH_HDR;
        end
      endcase

      if (chunk_end) begin
        phase_nxt = pad_r ? PH_PAD : PH_HDR;
        pad_nxt   = 1'b0;
        fcnt_nxt  = '0;
      end
    end

    has_err = (err_code != ST_RUNNING);
    if (has_err) err_nxt = 1'b1;

    if (phase_nxt == PH_RIFF) last_status = ST_NOT_RIFF;
    else if (phase_nxt inside {PH_SIZE, PH_WAVE}) last_status = ST_NOT_WAVE;
    else last_status = data_seen_nxt ? ST_DONE_OK : ST_NO_DATA;

    // re-arm for the next file on its last byte
    if (in_last_byte) begin
      phase_nxt     = PH_RIFF;
      fcnt_nxt      = '0;
      shift_nxt     = '0;
      tag_nxt       = '0;
      remain_nxt    = '0;
      fmt_seen_nxt  = 1'b0;
      data_seen_nxt = 1'b0;
      stereo_nxt    = 1'b1;
      err_nxt       = 1'b0;
      pad_nxt       = 1'b0;
    end
  end

  always_comb begin
    op.is_data   = (phase_r == PH_DATA);
    op.data_byte = in_data_byte;
    op.stereo    = stereo_r;
    op.restart   = chunk_end || in_last_byte;
    op.emit      = has_err || in_last_byte;
    op.status    = has_err ? err_code : last_status;
    op_valid     = accept && !err_r &&
                   ((phase_r == PH_DATA) || has_err || in_last_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      fcnt_r      <= '0;
      shift_r     <= '0;
      tag_r       <= '0;
      remain_r    <= '0;
      fmt_seen_r  <= 1'b0;
      data_seen_r <= 1'b0;
      stereo_r    <= 1'b1;
      err_r       <= 1'b0;
      pad_r       <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      fcnt_r      <= fcnt_nxt;
      shift_r     <= shift_nxt;
      tag_r       <= tag_nxt;
      remain_r    <= remain_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      data_seen_r <= data_seen_nxt;
      stereo_r    <= stereo_nxt;
      err_r       <= err_nxt;
      pad_r       <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_valid) begin
      rate_r <= cfg_data;
    end
  end

endmodule

FILE: hw/rtl/wpp_queue.sv
module wpp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  wpp_pkg::wpp_op_t wr_op,
  output logic             full,
  input  logic             rd_en,
  output wpp_pkg::wpp_op_t rd_op,
  output logic             empty
);
  import wpp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wpp_op_t       mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_op = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
    if (do_rd) rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CW'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_op;
  end

endmodule

FILE: hw/rtl/wpp_back.sv
module wpp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  wpp_pkg::wpp_op_t   q_op,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic               out_has_frame,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic [3:0]         out_status
);
  import wpp_pkg::*;

  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] left_r, left_nxt;
  logic        valid_r;
  logic        frame_r;
  logic [15:0] lv_r, rv_r;
  wpp_status_t st_r;

  logic        frame;
  logic [15:0] smp;
  logic [15:0] lv;
  logic        produces;
  logic        slot_free;

  assign smp = {q_op.data_byte, low_r};

  always_comb begin
    pos_nxt  = pos_r;
    low_nxt  = low_r;
    left_nxt = left_r;
    frame    = 1'b0;
    lv       = smp;
    if (q_op.is_data) begin
      if (!pos_r[0]) begin
        low_nxt = q_op.data_byte;
        pos_nxt = pos_r + 2'd1;
      end else if (q_op.stereo && pos_r == 2'd1) begin
        left_nxt = smp;
        pos_nxt  = 2'd2;
      end else begin
        frame   = 1'b1;
        lv      = q_op.stereo ? left_r : smp;
        pos_nxt = 2'd0;
      end
    end
    // drop a partial frame at chunk end or file end
    if (q_op.restart) pos_nxt = 2'd0;
  end

  assign produces  = frame || q_op.emit;
  assign slot_free = !valid_r || out_pop;
  assign q_pop     = !q_empty && (!produces || slot_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      low_r   <= '0;
      left_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pos_r  <= pos_nxt;
        low_r  <= low_nxt;
        left_r <= left_nxt;
      end
      if (q_pop && produces) valid_r <= 1'b1;
      else if (out_pop) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && produces) begin
      frame_r <= frame;
      lv_r    <= frame ? lv : 16'd0;
      rv_r    <= frame ? smp : 16'd0;
      st_r    <= q_op.emit ? q_op.status : ST_RUNNING;
    end
  end

  assign out_empty        = !valid_r;
  assign out_has_frame    = frame_r;
  assign out_left_sample  = lv_r;
  assign out_right_sample = rv_r;
  assign out_status       = st_r;

endmodule

FILE: tb/sv/wav_frame_checker.sv
module wav_frame_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic               out_has_frame,
  input  logic signed [15:0] out_left_sample,
  input  logic signed [15:0] out_right_sample,
  input  logic [3:0]         out_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import wpp_pkg::*;

  typedef struct packed {
    logic               has_frame;
    logic signed [15:0] left;
    logic signed [15:0] right;
    wpp_status_t        status;
  } frame_result_t;

  frame_result_t expected_frames[$];

  // Parser image: phase, byte counters, shift register and chunk bookkeeping.
  wpp_phase_t  phase;
  logic [4:0]  fcnt;
  logic [31:0] shreg;
  logic [31:0] tag;
  logic [31:0] remain;
  logic        fmt_ok;
  logic        data_ok;
  logic        stereo;
  logic        err_lat;
  logic        pad;
  logic [1:0]  fpos;
  logic [7:0]  lo_hold;
  logic [15:0] l_hold;
  logic [31:0] rate;

  function automatic void restart_file();
    phase   = PH_RIFF;
    fcnt    = '0;
    shreg   = '0;
    tag     = '0;
    remain  = '0;
    fmt_ok  = 1'b0;
    data_ok = 1'b0;
    stereo  = 1'b1;
    err_lat = 1'b0;
    pad     = 1'b0;
    fpos    = '0;
    lo_hold = '0;
    l_hold  = '0;
  endfunction

  function automatic void close_chunk();
    phase = pad ? PH_PAD : PH_HDR;
    pad   = 1'b0;
    fpos  = '0;
    fcnt  = '0;
  endfunction

  function automatic wpp_status_t enter_chunk();
    fcnt = '0;
    if (tag == TAG_FMT) begin
      if (remain < FMT_MIN_SIZE) return ST_FMT_SHORT;
      phase = PH_FMT;
    end else if (tag == TAG_DATA) begin
      if (data_ok) return ST_SECOND_DATA;
      if (!fmt_ok) return ST_DATA_NO_FMT;
      data_ok = 1'b1;
      fpos    = '0;
      phase   = PH_DATA;
    end else begin
      phase = PH_SKIP;
    end
    if (remain == '0) close_chunk();
    return ST_RUNNING;
  endfunction

  function automatic void consume_byte();
    remain = remain - 32'd1;
    if (remain == '0) close_chunk();
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    wpp_status_t   err;
    logic [4:0]    offs;
    logic [15:0]   chans;
    logic [15:0]   smp;
    frame_result_t res;
    logic          emit;
    err = ST_RUNNING;
    res = '0;
    res.status = ST_RUNNING;
    // after an error, swallow bytes until the end of the file
    if (err_lat) begin
      if (last) restart_file();
      return;
    end
    case (phase)
      PH_RIFF, PH_SIZE, PH_WAVE: begin
        shreg = {b, shreg[31:8]};
        fcnt  = fcnt + 5'd1;
        if (fcnt >= 5'd4) begin
          fcnt = '0;
          if (phase == PH_RIFF) begin
            if (shreg != TAG_RIFF) err = ST_NOT_RIFF;
            else phase = PH_SIZE;
          end else if (phase == PH_SIZE) begin
            phase = PH_WAVE;
          end else if (shreg != TAG_WAVE) begin
            err = ST_NOT_WAVE;
          end else begin
            phase = PH_HDR;
          end
        end
      end
      PH_HDR: begin
        shreg = {b, shreg[31:8]};
        fcnt  = fcnt + 5'd1;
        if (fcnt == 5'd4) tag = shreg;
        if (fcnt >= 5'd8) begin
          remain = shreg;
          pad    = shreg[0];
          err    = enter_chunk();
        end
      end
      PH_FMT: begin
        shreg = {b, shreg[31:8]};
        offs  = fcnt;
        if (fcnt < 5'd16) fcnt = fcnt + 5'd1;
        if (offs == 5'd1 && shreg[31:16] != AUDIO_FMT_PCM) begin
          err = ST_NOT_PCM;
        end else if (offs == 5'd3) begin
          chans = shreg[31:16];
          if (chans != 16'd1 && chans != 16'd2) err = ST_BAD_CHANNELS;
          else stereo = (chans == 16'd2);
        end else if (offs == 5'd7 && shreg != rate) begin
          err = ST_BAD_RATE;
        end else if (offs == 5'd15) begin
          if (shreg[31:16] != PCM_BITS) err = ST_BAD_BITS;
          else fmt_ok = 1'b1;
        end
        if (err == ST_RUNNING) consume_byte();
      end
      PH_DATA: begin
        if (!fpos[0]) begin
          lo_hold = b;
          fpos    = fpos + 2'd1;
        end else begin
          smp = {b, lo_hold};
          if (stereo && fpos == 2'd1) begin
            l_hold = smp;
            fpos   = 2'd2;
          end else begin
            res.has_frame = 1'b1;
            res.left      = stereo ? l_hold : smp;
            res.right     = smp;
            fpos          = '0;
          end
        end
        consume_byte();
      end
      PH_SKIP: consume_byte();
      default: phase = PH_HDR;
    endcase

    if (err != ST_RUNNING) begin
      res        = '0;
      res.status = err;
      err_lat    = 1'b1;
      if (last) restart_file();
      emit = 1'b1;
    end else if (last) begin
      if (phase == PH_RIFF) res.status = ST_NOT_RIFF;
      else if (phase == PH_SIZE || phase == PH_WAVE) res.status = ST_NOT_WAVE;
      else res.status = data_ok ? ST_DONE_OK : ST_NO_DATA;
      restart_file();
      emit = 1'b1;
    end else begin
      emit = res.has_frame;
    end
    if (emit) expected_frames.push_back(res);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      restart_file();
      rate = RATE_RESET;
      expected_frames.delete();
    end else begin
      if (in_push && !in_full) parse_byte(in_data_byte, in_last_byte);
      if (cfg_valid && cfg_ready) rate = cfg_data;
      if (out_pop && !out_empty) begin
        if (expected_frames.size() == 0) begin
          $display({"%0t: unexpected result, expected none, actual has_frame %0b",
                    " left %0d right %0d status %0d"},
                   $time, out_has_frame, out_left_sample, out_right_sample, out_status);
          fail_count = fail_count + 1;
        end else begin
          want = expected_frames.pop_front();
          check_field("has_frame", want.has_frame, out_has_frame);
          check_field("left_sample", want.left, out_left_sample);
          check_field("right_sample", want.right, out_right_sample);
          check_field("status", want.status, out_status);
        end
      end
    end
    pending_count <= expected_frames.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wpp_pkg::*;

  typedef enum int unsigned {
    FK_GOOD,
    FK_TRUNC,
    FK_BAD_RIFF,
    FK_BAD_WAVE,
    FK_BAD_PCM,
    FK_BAD_CH,
    FK_BAD_RATE,
    FK_BAD_BITS,
    FK_DATA_FIRST,
    FK_SECOND_DATA,
    FK_NO_DATA,
    FK_FMT_SHORT,
    FK_NOISE
  } wav_kind_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [7:0]         in_data_byte;
  logic               in_last_byte;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_has_frame;
  logic signed [15:0] out_left_sample;
  logic signed [15:0] out_right_sample;
  logic [3:0]         out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;

  int          fail_count;
  int          pending_count;
  int          idle_pct;
  int          stall_pct;
  logic        hold_start;
  int unsigned hold_left = 0;
  int unsigned bytes_sent;
  logic [31:0] cur_rate;
  logic [7:0]  file_q[$];

  wav_pcm16_stream_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_has_frame    (out_has_frame),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  wav_frame_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_has_frame    (out_has_frame),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_start && hold_left == 0) begin
      hold_left <= 400;
      out_pop   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void put8(logic [7:0] v);
    file_q.push_back(v);
  endfunction

  function automatic void put16(logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endfunction

  function automatic logic [7:0] sample_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned data_len();
    return ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 24);
  endfunction

  function automatic void put_fmt(logic [31:0] size, logic [15:0] code, logic [15:0] chans,
                                  logic [31:0] rate, logic [15:0] bits);
    put32(TAG_FMT);
    put32(size);
    put16(code);
    put16(chans);
    put32(rate);
    put32($urandom);
    put16(16'(chans * 2));
    put16(bits);
    for (int i = 16; i < size; i++) put8(sample_byte());
    if (size[0]) put8(8'h00);
  endfunction

  function automatic void put_data(int unsigned n, logic [31:0] declared);
    put32(TAG_DATA);
    put32(declared);
    repeat (n) put8(sample_byte());
    if (declared == n && declared[0]) put8(8'h00);
  endfunction

  // Unknown chunk with a random tag, odd sizes carry a pad byte.
  function automatic void put_junk();
    logic [31:0] jtag;
    logic [31:0] sz;
    jtag = $urandom;
    if (jtag == TAG_FMT || jtag == TAG_DATA) jtag = jtag ^ 32'h1;
    sz = $urandom_range(7);
    put32(jtag);
    put32(sz);
    repeat (sz) put8(sample_byte());
    if (sz[0]) put8(sample_byte());
  endfunction

  function automatic void build_file(wav_kind_t kind);
    logic [15:0] chans;
    logic [15:0] bad;
    int unsigned n;
    int unsigned cut;
    int unsigned idx;
    file_q.delete();
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 12)) put8(sample_byte());
      return;
    end
    put32(TAG_RIFF);
    put32($urandom);
    put32(TAG_WAVE);
    chans = 16'($urandom_range(1, 2));
    if ($urandom_range(1) == 1) put_junk();
    case (kind)
      FK_DATA_FIRST: begin
        n = data_len();
        put_data(n, n);
      end
      FK_FMT_SHORT: begin
        put32(TAG_FMT);
        put32(32'($urandom_range(15)));
        repeat ($urandom_range(20)) put8(sample_byte());
      end
      FK_BAD_PCM: begin
        bad = 16'($urandom);
        if (bad == AUDIO_FMT_PCM) bad = 16'd0;
        put_fmt(16, bad, chans, cur_rate, PCM_BITS);
      end
      FK_BAD_CH: begin
        case ($urandom_range(2))
          0: bad = 16'd0;
          1: bad = 16'd3;
          default: bad = 16'($urandom);
        endcase
        if (bad == 16'd1 || bad == 16'd2) bad = 16'hFFFF;
        put_fmt(16, AUDIO_FMT_PCM, bad, cur_rate, PCM_BITS);
      end
      FK_BAD_RATE: put_fmt(16, AUDIO_FMT_PCM, chans,
                           cur_rate ^ (32'h1 << $urandom_range(31)), PCM_BITS);
      FK_BAD_BITS: begin
        bad = 16'($urandom);
        if (bad == PCM_BITS) bad = 16'd8;
        put_fmt(16, AUDIO_FMT_PCM, chans, cur_rate, bad);
      end
      default: begin
        put_fmt(($urandom_range(3) == 0) ? 16 + $urandom_range(1, 5) : 16,
                AUDIO_FMT_PCM, chans, cur_rate, PCM_BITS);
        // repeated fmt flips the channel mode
        if ($urandom_range(3) == 0)
          put_fmt(16, AUDIO_FMT_PCM, 16'd3 - chans, cur_rate, PCM_BITS);
        if (kind != FK_NO_DATA) begin
          n = data_len();
          put_data(n, (kind == FK_TRUNC && $urandom_range(1) == 1) ? 32'hFFFF_FFFF : n);
        end
        if (kind == FK_SECOND_DATA) begin
          n = data_len();
          put_data(n, n);
        end
        if ($urandom_range(1) == 1) put_junk();
      end
    endcase
    // give the fmt error files a data tail that must be ignored
    if (kind == FK_BAD_PCM || kind == FK_BAD_CH || kind == FK_BAD_RATE || kind == FK_BAD_BITS)
      put_data(4, 4);
    if (kind == FK_BAD_RIFF) begin
      idx = $urandom_range(3);
      file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
    end else if (kind == FK_BAD_WAVE) begin
      idx = 8 + $urandom_range(3);
      file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
    end else if (kind == FK_TRUNC) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) file_q.delete(file_q.size() - 1);
    end
  endfunction

  function automatic wav_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return FK_GOOD;
    if (r < 67) return FK_TRUNC;
    return wav_kind_t'($urandom_range(int'(FK_NOISE), int'(FK_BAD_RIFF)));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_file();
    int unsigned n;
    n = file_q.size();
    for (int unsigned i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
    bytes_sent += n;
  endtask

  // Hold the input until every expected result is out, then let the
  // builder settle on requests that yield nothing.
  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_rate = v;
  endtask

  initial begin
    in_push      = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_start   = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    cur_rate     = RATE_RESET;
    bytes_sent   = 0;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // one file of each kind at the reset rate
    for (int k = int'(FK_GOOD); k <= int'(FK_NOISE); k++) begin
      build_file(wav_kind_t'(k));
      send_file();
    end

    for (int p = 0; p < 5; p++) begin
      drain_results();
      case (p)
        0: write_rate(32'h0000_0000);
        1: write_rate(32'hFFFF_FFFF);
        2: write_rate($urandom);
        3: write_rate(32'd48000);
        default: write_rate(RATE_RESET);
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 51; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 51; end
        default: begin idle_pct = 32; stall_pct <= 32; end
      endcase
      if (p == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      bytes_sent = 0;
      while (bytes_sent < 140) begin
        build_file(pick_kind());
        send_file();
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: wav_pcm16_stream_parser.f
hw/rtl/wpp_pkg.sv
hw/rtl/wpp_front.sv
hw/rtl/wpp_queue.sv
hw/rtl/wpp_back.sv
hw/rtl/wav_pcm16_stream_parser.sv
tb/sv/wav_frame_checker.sv
tb/sv/tb_top.sv
